FILE: sv/fav_pkg.sv
// shared types and constants for the frame average filter
package fav_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 18;
    localparam int TOT_W      = SUM_W + 1;
    localparam int WORD_W     = SUM_W + PIX_W;
    localparam int N_W        = 11;
    localparam int W_W        = 17;
    localparam int PROD_W     = PIX_W + W_W;
    localparam int DIV_SHIFT  = TOT_W;
    localparam int RCP_W      = DIV_SHIFT + 1;
    localparam int MULQ_W     = TOT_W + RCP_W;
    localparam int STEP_W     = $clog2(RCP_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int FRAMES_MAX = 1024;
    localparam int N_RST      = 10;
    localparam int W_RST      = 6554;
    localparam int PPF_DEFAULT = 307200;

    localparam logic [W_W-1:0]   Q16_ONE   = W_W'(65536);
    localparam logic [PIX_W-1:0] PIX_MAX   = '1;
    localparam int               Q16_HALF  = 32768;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = FIFO_PTR_W + 1;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_RUNNING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Q16   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS       = 3'd4;

    // control carried with one pixel through the update pipeline
    typedef struct packed {
        logic             running;
        logic             first;
        logic             done;
        logic             last;
        logic [PIX_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] average_pixel;
        logic             last_of_frame;
    } t_result;

endpackage

FILE: sv/fav_store.sv
// pixel memory holding the average and the running sum, with clear sweep after reset
module fav_store #(
    parameter int DEPTH  = 524288,
    parameter int ADDR_W = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [fav_pkg::WORD_W-1:0] o_rdata,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [fav_pkg::WORD_W-1:0] i_wdata,
    output logic                       o_ready
);
    import fav_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = i_we;
            w_waddr = i_waddr;
            w_wdata = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

    assign o_ready = !r_clr_busy;

endmodule

FILE: sv/fav_recip.sv
// serial restoring divider producing floor(2^19 / n) for the block average
module fav_recip (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fav_pkg::N_W-1:0]   i_n,
    output logic                      o_busy,
    output logic [fav_pkg::RCP_W-1:0] o_recip
);
    import fav_pkg::*;

    localparam logic [RCP_W-1:0] DIVIDEND = RCP_W'(1) << DIV_SHIFT;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [N_W:0]      r_rem;
    logic [RCP_W-1:0]  r_quo;
    logic [N_W:0]      w_shift;
    logic              w_fit;

    assign w_shift = {r_rem[N_W-1:0], DIVIDEND[r_step]};
    assign w_fit   = w_shift >= {1'b0, i_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(RCP_W - 1);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (w_shift - {1'b0, i_n}) : w_shift;
            r_step <= r_step - STEP_W'(1);
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_quo[r_step] <= w_fit;
        end
    end

    assign o_busy  = r_busy;
    assign o_recip = r_quo;

endmodule

FILE: sv/fav_update.sv
// four-stage read-modify-write datapath: running blend or block sum and divide
module fav_update #(
    parameter int POS_W = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [POS_W-1:0]           i_pos,
    input  fav_pkg::t_item             i_item,
    input  logic [fav_pkg::WORD_W-1:0] i_rdata,
    input  logic [fav_pkg::W_W-1:0]    i_weight,
    input  logic [fav_pkg::N_W-1:0]    i_n,
    input  logic [fav_pkg::RCP_W-1:0]  i_recip,
    input  logic [POS_W-1:0]           i_query_pos,
    output logic                       o_hit,
    output logic                       o_we,
    output logic [POS_W-1:0]           o_waddr,
    output logic [fav_pkg::WORD_W-1:0] o_wdata,
    output logic                       o_push,
    output fav_pkg::t_result           o_result
);
    import fav_pkg::*;

    // stage 1: memory data arrives
    logic             r_v1;
    logic [POS_W-1:0] r_pos1;
    t_item            r_c1;
    logic [PIX_W-1:0] w_avg_old;
    logic [SUM_W-1:0] w_sum_old;
    logic [W_W-1:0]   w_w_inv;
    logic [PROD_W-1:0] w_keep_p;
    logic [PROD_W-1:0] w_add_p;
    logic [TOT_W-1:0] w_tot1;
    logic [TOT_W-1:0] w_td1;

    // stage 2
    logic              r_v2;
    logic [POS_W-1:0]  r_pos2;
    t_item             r_c2;
    logic [PROD_W-1:0] r_keep2;
    logic [PROD_W-1:0] r_add2;
    logic [TOT_W-1:0]  r_tot2;
    logic [TOT_W-1:0]  r_td2;
    logic [WORD_W-1:0] r_old2;
    logic [PROD_W-1:0] w_keep_rnd;
    logic [PROD_W-1:0] w_add_rnd;
    logic [PIX_W+1:0]  w_blend;
    logic [PIX_W-1:0]  w_avg2;
    logic [SUM_W-1:0]  w_sum2;
    logic [MULQ_W-1:0] w_prod2;

    // stage 3
    logic              r_v3;
    logic [POS_W-1:0]  r_pos3;
    t_item             r_c3;
    logic [PIX_W-1:0]  r_avg3;
    logic [SUM_W-1:0]  r_sum3;
    logic [TOT_W-1:0]  r_td3;
    logic [MULQ_W-1:0] r_prod3;
    logic [RCP_W-1:0]  w_q0;
    logic [TOT_W-1:0]  w_qn;

    // stage 4: write back
    logic              r_v4;
    logic [POS_W-1:0]  r_pos4;
    t_item             r_c4;
    logic [PIX_W-1:0]  r_avg4;
    logic [SUM_W-1:0]  r_sum4;
    logic [TOT_W-1:0]  r_td4;
    logic [PIX_W-1:0]  r_q4;
    logic              r_big4;
    logic [TOT_W-1:0]  r_qn4;
    logic [TOT_W-1:0]  w_rem;
    logic              w_incr;
    logic [PIX_W-1:0]  w_quot;
    logic [PIX_W-1:0]  w_avg_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign w_avg_old = i_rdata[PIX_W-1:0];
    assign w_sum_old = i_rdata[WORD_W-1:PIX_W];
    assign w_w_inv   = Q16_ONE - i_weight;
    assign w_keep_p  = PROD_W'(w_avg_old) * PROD_W'(w_w_inv);
    assign w_add_p   = PROD_W'(r_c1.sample) * PROD_W'(i_weight);
    assign w_tot1    = r_c1.first ? TOT_W'(r_c1.sample)
                                  : TOT_W'(w_sum_old) + TOT_W'(r_c1.sample);
    // rounding offset n/2 folded in before the divide
    assign w_td1     = w_tot1 + TOT_W'(i_n >> 1);

    always_ff @(posedge i_clk) begin
        r_pos1  <= i_pos;
        r_c1    <= i_item;
        r_pos2  <= r_pos1;
        r_c2    <= r_c1;
        r_keep2 <= w_keep_p;
        r_add2  <= w_add_p;
        r_tot2  <= w_tot1;
        r_td2   <= w_td1;
        r_old2  <= i_rdata;
    end

    assign w_keep_rnd = r_keep2 + PROD_W'(Q16_HALF);
    assign w_add_rnd  = r_add2 + PROD_W'(Q16_HALF);
    assign w_blend    = (PIX_W + 2)'(w_keep_rnd[PROD_W-1:16])
                      + (PIX_W + 2)'(w_add_rnd[PROD_W-1:16]);

    always_comb begin
        if (!r_c2.running) begin
            w_avg2 = r_old2[PIX_W-1:0];
            w_sum2 = r_tot2[SUM_W-1:0];
        end else if (r_c2.first) begin
            w_avg2 = r_c2.sample;
            w_sum2 = r_old2[WORD_W-1:PIX_W];
        end else begin
            w_avg2 = (w_blend > (PIX_W + 2)'(PIX_MAX)) ? PIX_MAX : w_blend[PIX_W-1:0];
            w_sum2 = r_old2[WORD_W-1:PIX_W];
        end
    end

    assign w_prod2 = MULQ_W'(r_td2) * MULQ_W'(i_recip);

    always_ff @(posedge i_clk) begin
        r_pos3  <= r_pos2;
        r_c3    <= r_c2;
        r_avg3  <= w_avg2;
        r_sum3  <= w_sum2;
        r_td3   <= r_td2;
        r_prod3 <= w_prod2;
    end

    // estimate is exact or one low; stage 4 corrects it
    assign w_q0 = r_prod3[MULQ_W-1:DIV_SHIFT];
    assign w_qn = TOT_W'(w_q0[PIX_W-1:0]) * TOT_W'(i_n);

    always_ff @(posedge i_clk) begin
        r_pos4 <= r_pos3;
        r_c4   <= r_c3;
        r_avg4 <= r_avg3;
        r_sum4 <= r_sum3;
        r_td4  <= r_td3;
        r_q4   <= w_q0[PIX_W-1:0];
        r_big4 <= |w_q0[RCP_W-1:PIX_W];
        r_qn4  <= w_qn;
    end

    assign w_rem  = r_td4 - r_qn4;
    assign w_incr = w_rem >= TOT_W'(i_n);
    assign w_quot = (r_big4 || (w_incr && r_q4 == PIX_MAX)) ? PIX_MAX
                                                           : r_q4 + PIX_W'(w_incr);
    assign w_avg_new = (!r_c4.running && r_c4.done) ? w_quot : r_avg4;

    assign o_we     = r_v4;
    assign o_waddr  = r_pos4;
    assign o_wdata  = {r_sum4, w_avg_new};
    assign o_push   = r_v4;
    assign o_result = '{average_pixel: w_avg_new, last_of_frame: r_c4.last};

    // a pixel still in flight to the memory blocks a new read of its entry
    assign o_hit = (r_v1 && r_pos1 == i_query_pos) || (r_v2 && r_pos2 == i_query_pos)
                || (r_v3 && r_pos3 == i_query_pos) || (r_v4 && r_pos4 == i_query_pos);

endmodule

FILE: sv/fav_fifo.sv
// small result queue between the write-back stage and the output stream
module fav_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fav_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output fav_pkg::t_result o_data
);
    import fav_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [CREDIT_W-1:0]   r_count;
    logic                  w_pop;

    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FIFO_PTR_W'(1);
            end
            r_count <= r_count + CREDIT_W'(i_push) - CREDIT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

endmodule

FILE: sv/frame_average_filter.sv
// each accepted input transaction gives one result on the output stream
// throughput: one pixel per cycle when not stalled; a frame shorter than 5 pixels
//   stalls while the same memory entry is in the 4-stage read-modify-write path
// reset: synchronous, active low; input is held off while the average memory is
//   cleared, and while the divider runs after each nonzero frame_count_target write
module frame_average_filter #(
    parameter int MAX_PIXELS = 524288
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // average_pixel
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fav_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fav_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fav_pkg::*;

    localparam int POS_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PPF_W   = $clog2(MAX_PIXELS + 1);
    localparam int PPF_RST = (PPF_DEFAULT > MAX_PIXELS) ? MAX_PIXELS : PPF_DEFAULT;

    logic             r_running;
    logic [N_W-1:0]   r_n;
    logic [W_W-1:0]   r_weight;
    logic             r_wide;
    logic [PPF_W-1:0] r_ppf;
    logic [POS_W-1:0] r_pos;
    logic [N_W-1:0]   r_frames;
    logic [CREDIT_W-1:0] r_credit;

    logic [POS_W-1:0] n_pos;
    logic [N_W-1:0]   n_frames;

    logic [N_W-1:0]   w_cfg_n;
    logic [W_W-1:0]   w_cfg_w;
    logic [31:0]      w_cfg_p;
    logic             w_restart;
    logic             w_rcp_start;

    logic             w_acc;
    logic             w_pop;
    logic             w_last;
    logic             w_first;
    logic             w_done;
    logic [16:0]      w_wide_sum;
    logic [PIX_W-1:0] w_sample;
    t_item            w_item;

    logic              w_store_ready;
    logic [WORD_W-1:0] w_rdata;
    logic              w_we;
    logic [POS_W-1:0]  w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic              w_rcp_busy;
    logic [RCP_W-1:0]  w_recip;
    logic              w_hit;
    logic              w_push;
    t_result           w_result;
    t_result           w_out;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_n = (i_cfg_data[N_W-1:0] > N_W'(FRAMES_MAX)) ? N_W'(FRAMES_MAX)
                                                              : i_cfg_data[N_W-1:0];
    assign w_cfg_w = (i_cfg_data[W_W-1:0] > Q16_ONE) ? Q16_ONE : i_cfg_data[W_W-1:0];
    always_comb begin
        w_cfg_p = 32'(i_cfg_data);
        if (w_cfg_p == '0) begin
            w_cfg_p = 32'd1;
        end else if (w_cfg_p > 32'(MAX_PIXELS)) begin
            w_cfg_p = 32'(MAX_PIXELS);
        end
    end

    assign w_restart = i_cfg_valid &&
        (i_cfg_index == REG_RUNNING_MODE || i_cfg_index == REG_PIXELS);
    assign w_rcp_start = i_cfg_valid && i_cfg_index == REG_FRAME_TARGET &&
        i_cfg_data[N_W-1:0] != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_n       <= N_W'(N_RST);
            r_weight  <= W_W'(W_RST);
            r_wide    <= 1'b0;
            r_ppf     <= PPF_W'(PPF_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RUNNING_MODE: r_running <= i_cfg_data[0];
                REG_FRAME_TARGET: begin
                    if (i_cfg_data[N_W-1:0] != '0) begin
                        r_n <= w_cfg_n;
                    end
                end
                REG_WEIGHT_Q16:   r_weight <= w_cfg_w;
                REG_WIDE_SAMPLES: r_wide <= i_cfg_data[0];
                REG_PIXELS:       r_ppf <= w_cfg_p[PPF_W-1:0];
                default: ;
            endcase
        end
    end

    // sample reduction to 8 bits
    assign w_wide_sum = {1'b0, s_axis_tdata} + 17'd128;
    always_comb begin
        if (r_wide) begin
            w_sample = w_wide_sum[16] ? PIX_MAX : w_wide_sum[15:8];
        end else begin
            w_sample = (|s_axis_tdata[15:8]) ? PIX_MAX : s_axis_tdata[7:0];
        end
    end

    // frame position and frame counter
    assign w_last  = (PPF_W'(r_pos) + PPF_W'(1)) >= r_ppf;
    assign w_first = r_frames == '0;
    assign w_done  = !r_running && (({1'b0, r_frames} + (N_W + 1)'(1)) >= {1'b0, r_n});

    assign w_item = '{running: r_running, first: w_first, done: w_done,
                      last: w_last, sample: w_sample};

    always_comb begin
        n_pos    = r_pos;
        n_frames = r_frames;
        if (w_acc) begin
            if (w_last) begin
                n_pos = '0;
                if (r_running) begin
                    if (r_frames < r_n) begin
                        n_frames = r_frames + N_W'(1);
                    end
                end else begin
                    n_frames = w_done ? '0 : r_frames + N_W'(1);
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_pos    <= '0;
            r_frames <= '0;
        end else begin
            r_pos    <= n_pos;
            r_frames <= n_frames;
        end
    end

    // credits cover the pipeline and the result queue
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_pop = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = w_store_ready && !w_rcp_busy && !w_hit &&
                           (r_credit < CREDIT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CREDIT_W'(w_acc) - CREDIT_W'(w_pop);
        end
    end

    fav_store #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (POS_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (r_pos),
        .o_rdata (w_rdata),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .o_ready (w_store_ready)
    );

    // the divider runs from the stored frame target so it holds for the whole sweep
    fav_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rcp_start),
        .i_n     (r_n),
        .o_busy  (w_rcp_busy),
        .o_recip (w_recip)
    );

    fav_update #(
        .POS_W (POS_W)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_acc),
        .i_pos       (r_pos),
        .i_item      (w_item),
        .i_rdata     (w_rdata),
        .i_weight    (r_weight),
        .i_n         (r_n),
        .i_recip     (w_recip),
        .i_query_pos (r_pos),
        .o_hit       (w_hit),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_push      (w_push),
        .o_result    (w_result)
    );

    fav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = w_out.average_pixel;
    assign m_axis_tlast = w_out.last_of_frame;

endmodule

FILE: sv/fav_checker.sv
// port-level checker for the frame average filter, bound to the top level
module fav_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import fav_pkg::*;

    logic [CREDIT_W:0] r_outstanding;

    // transactions accepted on the input and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding
                + (CREDIT_W + 1)'(s_axis_tvalid && s_axis_tready)
                - (CREDIT_W + 1)'(m_axis_tvalid && m_axis_tready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output result changed while stalled");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_outstanding != '0)
        else $error("result without a pending input pixel");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= (CREDIT_W + 1)'(FIFO_DEPTH))
        else $error("more pixels in flight than the result queue holds");

    a_reset_hold: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input accepted right after reset");

endmodule

bind frame_average_filter fav_checker u_fav_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
